/* design/bengali_conjunct_composer_defines.svh */
// Assertion macros for the top-level composer, which checks its own logic.
`ifndef BENGALI_CONJUNCT_COMPOSER_DEFINES_SVH
`define BENGALI_CONJUNCT_COMPOSER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BCC_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bcc assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bcc assertion failed");

`endif

/* design/bcc_pkg.sv */
package bcc_pkg;

  localparam logic [20:0] CpVirama  = 21'h009CD;
  localparam logic [20:0] CpVowelA  = 21'h00985;
  localparam logic [20:0] CpNukta   = 21'h009BC;
  localparam logic [20:0] CpReplace = 21'h0FFFD;
  localparam logic [20:0] CpMax     = 21'h10FFFF;

  localparam int unsigned JobDepth  = 4;
  localparam int unsigned JobPtrW   = $clog2(JobDepth);
  localparam int unsigned JobCountW = $clog2(JobDepth + 1);

  // One composed unit of output: an optional virama followed by a code point.
  typedef struct packed {
    logic        virama;
    logic [20:0] cp;
    logic [2:0]  cp_len;
  } job_t;

  typedef struct packed {
    logic decoder_idle;
  } front_status_t;

  function automatic logic is_consonant(input logic [20:0] cp);
    logic r;
    r = (cp >= 21'h00995 && cp <= 21'h009B9) ||
        cp == 21'h009DC || cp == 21'h009DD || cp == 21'h009DF;
    return r;
  endfunction

  function automatic logic is_indep_vowel(input logic [20:0] cp);
    logic r;
    r = cp inside {21'h00985, 21'h00986, 21'h00987, 21'h00988,
                   21'h00989, 21'h0098A, 21'h0098B, 21'h0098C,
                   21'h0098F, 21'h00990, 21'h00993, 21'h00994};
    return r;
  endfunction

  // Dependent sign of an independent vowel; the vowel itself where there is none.
  function automatic logic [20:0] matra_or_self(input logic [20:0] cp);
    logic [20:0] m;
    case (cp)
      21'h00986: m = 21'h009BE;
      21'h00987: m = 21'h009BF;
      21'h00988: m = 21'h009C0;
      21'h00989: m = 21'h009C1;
      21'h0098A: m = 21'h009C2;
      21'h0098B: m = 21'h009C3;
      21'h0098F: m = 21'h009C7;
      21'h00990: m = 21'h009C8;
      21'h00993: m = 21'h009CB;
      21'h00994: m = 21'h009CC;
      default:   m = cp;
    endcase
    return m;
  endfunction

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    logic [2:0] n;
    if (cp <= 21'h0007F) begin
      n = 3'd1;
    end else if (cp <= 21'h007FF) begin
      n = 3'd2;
    end else if (cp <= 21'h0FFFF) begin
      n = 3'd3;
    end else if (cp <= CpMax) begin
      n = 3'd4;
    end else begin
      n = 3'd0;
    end
    return n;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [2:0] len,
                                           input logic [1:0] k);
    logic [2:0] sh;
    logic [7:0] b;
    sh = len - 3'd1 - {1'b0, k};
    if (k == 2'd0) begin
      case (len)
        3'd1:    b = cp[7:0];
        3'd2:    b = {3'b110, cp[10:6]};
        3'd3:    b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      case (sh)
        3'd0:    b = {2'b10, cp[5:0]};
        3'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

/* design/bcc_front.sv */
module bcc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  take,
  input  logic [7:0]            in_byte,
  input  logic                  component_last,
  input  logic                  text_last,
  output logic                  job_push,
  output bcc_pkg::job_t         job,
  output bcc_pkg::front_status_t status
);
  import bcc_pkg::*;

  logic        after_consonant, after_consonant_next;
  logic [20:0] partial_codepoint, partial_codepoint_next;
  logic [1:0]  bytes_remaining, bytes_remaining_next;
  logic        bad_continuation, bad_continuation_next;

  logic        cp_done;
  logic [20:0] cp;
  logic        emit;
  logic [20:0] emit_cp;

  always_comb begin
    after_consonant_next   = after_consonant;
    partial_codepoint_next = partial_codepoint;
    bytes_remaining_next   = bytes_remaining;
    bad_continuation_next  = bad_continuation;
    cp_done = 1'b0;
    cp      = {13'd0, in_byte};
    emit    = 1'b0;
    emit_cp = cp;
    job     = '0;

    if (bytes_remaining == 2'd0) begin
      if (in_byte[7] == 1'b0) begin
        cp_done = 1'b1;
      end else if (in_byte[7:5] == 3'b110) begin
        partial_codepoint_next = {16'd0, in_byte[4:0]};
        bytes_remaining_next   = 2'd1;
        bad_continuation_next  = 1'b0;
      end else if (in_byte[7:4] == 4'b1110) begin
        partial_codepoint_next = {17'd0, in_byte[3:0]};
        bytes_remaining_next   = 2'd2;
        bad_continuation_next  = 1'b0;
      end else if (in_byte[7:3] == 5'b11110) begin
        partial_codepoint_next = {18'd0, in_byte[2:0]};
        bytes_remaining_next   = 2'd3;
        bad_continuation_next  = 1'b0;
      end
    end else begin
      if (!bad_continuation) begin
        if (in_byte[7:6] != 2'b10) begin
          bad_continuation_next = 1'b1;
        end else begin
          partial_codepoint_next = {partial_codepoint[14:0], in_byte[5:0]};
        end
      end
      bytes_remaining_next = bytes_remaining - 2'd1;
      if (bytes_remaining_next == 2'd0) begin
        cp_done = 1'b1;
        cp = bad_continuation_next ? CpReplace : partial_codepoint_next;
        partial_codepoint_next = '0;
        bad_continuation_next  = 1'b0;
      end
    end

    emit_cp = cp;
    if (cp_done) begin
      if (is_consonant(cp)) begin
        job.virama = after_consonant;
        emit = 1'b1;
        after_consonant_next = 1'b1;
      end else if (is_indep_vowel(cp)) begin
        if (after_consonant) begin
          emit    = (cp != CpVowelA);
          emit_cp = matra_or_self(cp);
        end else begin
          emit = 1'b1;
        end
        after_consonant_next = 1'b0;
      end else if (cp == CpNukta) begin
        emit = 1'b1;
      end else begin
        emit = 1'b1;
        after_consonant_next = 1'b0;
      end
    end

    job.cp     = emit_cp;
    job.cp_len = emit ? utf8_len(emit_cp) : 3'd0;

    if (component_last || text_last) begin
      bytes_remaining_next   = 2'd0;
      partial_codepoint_next = '0;
      bad_continuation_next  = 1'b0;
    end
    if (text_last) begin
      after_consonant_next = 1'b0;
    end
  end

  assign job_push = take && cp_done && (job.virama || job.cp_len != 3'd0);
  assign status.decoder_idle = (bytes_remaining == 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      after_consonant   <= 1'b0;
      partial_codepoint <= '0;
      bytes_remaining   <= 2'd0;
      bad_continuation  <= 1'b0;
    end else if (take) begin
      after_consonant   <= after_consonant_next;
      partial_codepoint <= partial_codepoint_next;
      bytes_remaining   <= bytes_remaining_next;
      bad_continuation  <= bad_continuation_next;
    end
  end

endmodule

/* design/bcc_fifo.sv */
module bcc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  bcc_pkg::job_t wr_data,
  input  logic          rd_en,
  output bcc_pkg::job_t rd_data,
  output logic          full,
  output logic          not_empty
);
  import bcc_pkg::*;

  job_t                 mem [JobDepth];
  logic [JobPtrW-1:0]   wr_ptr;
  logic [JobPtrW-1:0]   rd_ptr;
  logic [JobCountW-1:0] count;

  assign full      = (count == JobCountW'(JobDepth));
  assign not_empty = (count != '0);
  assign rd_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* design/bcc_back.sv */
module bcc_back (
  input  logic          clk,
  input  logic          rst,
  input  bcc_pkg::job_t job_in,
  input  logic          job_ready,
  output logic          job_pop,
  input  logic          pop,
  output logic          empty,
  output logic [7:0]    out_byte,
  output logic          run_last
);
  import bcc_pkg::*;

  job_t       job;
  logic       busy;
  logic [2:0] pos;
  logic       out_valid;

  logic [2:0] total;
  logic [2:0] cp_pos;
  logic       last;
  logic       advance;
  logic [7:0] byte_sel;

  assign total   = (job.virama ? 3'd3 : 3'd0) + job.cp_len;
  assign last    = (pos == total - 3'd1);
  assign advance = busy && (!out_valid || pop);
  assign job_pop = job_ready && (!busy || (advance && last));
  assign cp_pos  = job.virama ? pos - 3'd3 : pos;
  assign empty   = !out_valid;

  always_comb begin
    if (job.virama && pos < 3'd3) begin
      byte_sel = utf8_byte(CpVirama, 3'd3, pos[1:0]);
    end else begin
      byte_sel = utf8_byte(job.cp, job.cp_len, cp_pos[1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (advance) begin
        if (last) begin
          busy <= 1'b0;
        end else begin
          pos <= pos + 3'd1;
        end
      end
      if (advance) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
    if (advance) begin
      out_byte <= byte_sel;
      run_last <= last;
    end
  end

endmodule

/* design/bengali_conjunct_composer.sv */
// Channel  | Direction | Handshake    | Payload
// input    | in        | push / full  | in_byte, component_last, text_last
// result   | out       | pop / empty  | out_byte, run_last
//
// The decoder takes one byte per cycle while its job queue has room.
// Each decoded code point gives up to six result bytes, sent one per cycle while they are popped,
// so the result side sets the sustained rate.
// Each byte passes the job queue, the back end's job register and the output register.
// Reset is synchronous and clears the decoder state, the queue and the output valid flag.
// A held result stalls the back end only; the front keeps taking bytes until the queue fills.
`include "bengali_conjunct_composer_defines.svh"

module bengali_conjunct_composer (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       component_last,
  input  logic       text_last,
  input  logic       pop,
  output logic       empty,
  output logic [7:0] out_byte,
  output logic       run_last
);
  import bcc_pkg::*;

  logic          take;
  logic          job_push;
  job_t          job_w;
  job_t          job_r;
  front_status_t status;
  logic          q_full;
  logic          q_not_empty;
  logic          job_pop;

  assign full = q_full;
  assign take = push && !q_full;

  bcc_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .in_byte        (in_byte),
    .component_last (component_last),
    .text_last      (text_last),
    .job_push       (job_push),
    .job            (job_w),
    .status         (status)
  );

  bcc_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (job_push),
    .wr_data   (job_w),
    .rd_en     (job_pop),
    .rd_data   (job_r),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  bcc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_in    (job_r),
    .job_ready (q_not_empty),
    .job_pop   (job_pop),
    .pop       (pop),
    .empty     (empty),
    .out_byte  (out_byte),
    .run_last  (run_last)
  );

  `BCC_ASSERT_NEXT(a_ascii_makes_job, take && status.decoder_idle && !in_byte[7], q_not_empty)
  `BCC_ASSERT_NEXT(a_run_unbroken, !empty && !run_last, !empty)
  `BCC_ASSERT_SAME(a_push_needs_room, job_push, !q_full)

endmodule
